[hw/rtl/quoted_argument_tokenizer_top_macros.svh]
// Assertion macros for the quoted argument tokenizer
`ifndef QUOTED_ARGUMENT_TOKENIZER_TOP_MACROS_SVH
`define QUOTED_ARGUMENT_TOKENIZER_TOP_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define QAT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication checked at every clock edge outside reset
`define QAT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked at the next clock edge outside reset
`define QAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/qat_pkg.sv]
// Types, constants and helpers shared by the tokenizer modules
package qat_pkg;

  localparam int MaxArgs = 12;
  localparam int CntW    = $clog2(MaxArgs + 1);
  localparam int MaxRes  = 3;
  localparam int QDepth  = 4;
  localparam int QAW     = $clog2(QDepth);
  localparam int QLevW   = $clog2(QDepth + 1);
  localparam int TdataW  = 24;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;

  typedef enum logic [1:0] {
    KindByte = 2'd0,
    KindEnd  = 2'd1,
    KindLine = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StUnmatched = 2'd1,
    StOverflow  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ModeBetween = 3'b001,
    ModePlain   = 3'b010,
    ModeQuoted  = 3'b100
  } mode_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic [3:0] token_index;
    status_t    status;
    logic [3:0] arg_count;
    logic       last;
  } res_t;

  function automatic res_t mk_res(kind_t k, logic [7:0] b, logic [3:0] idx,
                                  status_t st, logic [3:0] cnt);
    res_t r;
    r.kind        = k;
    r.out_byte    = b;
    r.token_index = idx;
    r.status      = st;
    r.arg_count   = cnt;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

[hw/rtl/qat_parse.sv]
// Tokenizer state and the result words produced for one input word
module qat_parse (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      in_byte,
  input  logic            line_end,
  output qat_pkg::res_t   res [qat_pkg::MaxRes],
  output logic [1:0]      res_n
);

  qat_pkg::mode_t             mode, mode_next;
  logic                       dquote, dquote_next;
  logic                       esc, esc_next;
  logic [qat_pkg::CntW-1:0]   cnt, cnt_next;
  logic                       ovf, ovf_next;

  always_comb begin
    logic [1:0]               k;
    logic [qat_pkg::CntW-1:0] cur;
    logic                     sep;
    logic                     is_quote;
    qat_pkg::status_t         st;
    k           = 2'd0;
    cur         = (cnt != '0) ? cnt - qat_pkg::CntW'(1) : '0;
    sep         = (in_byte == qat_pkg::ChSpace) || (in_byte == qat_pkg::ChTab);
    is_quote    = (in_byte == qat_pkg::ChSquote) || (in_byte == qat_pkg::ChDquote);
    st          = qat_pkg::StOk;
    mode_next   = mode;
    dquote_next = dquote;
    esc_next    = esc;
    cnt_next    = cnt;
    ovf_next    = ovf;
    for (int i = 0; i < qat_pkg::MaxRes; i++) begin
      res[i] = '0;
    end

    if (line_end) begin
      if (ovf) begin
        st = qat_pkg::StOverflow;
      end else if (mode != qat_pkg::ModeBetween) begin
        // trailing backslash stays a literal byte
        if (esc) begin
          res[k] = qat_pkg::mk_res(qat_pkg::KindByte, qat_pkg::ChBslash, 4'(cur),
                                   qat_pkg::StOk, 4'd0);
          k = k + 2'd1;
        end
        if (mode == qat_pkg::ModePlain) begin
          res[k] = qat_pkg::mk_res(qat_pkg::KindEnd, 8'h00, 4'(cur), qat_pkg::StOk, 4'd0);
          k = k + 2'd1;
        end else begin
          st = qat_pkg::StUnmatched;
        end
      end
      res[k] = qat_pkg::mk_res(qat_pkg::KindLine, 8'h00, 4'd0, st, 4'(cnt));
      k = k + 2'd1;
      mode_next   = qat_pkg::ModeBetween;
      dquote_next = 1'b0;
      esc_next    = 1'b0;
      cnt_next    = '0;
      ovf_next    = 1'b0;
    end else if (!ovf) begin
      priority if (mode == qat_pkg::ModeBetween) begin
        if (sep) begin
          // skip separators
        end else if (cnt >= qat_pkg::CntW'(qat_pkg::MaxArgs)) begin
          ovf_next = 1'b1;
        end else begin
          cnt_next = cnt + qat_pkg::CntW'(1);
          esc_next = 1'b0;
          if (is_quote) begin
            mode_next   = qat_pkg::ModeQuoted;
            dquote_next = (in_byte == qat_pkg::ChDquote);
          end else if (in_byte == qat_pkg::ChBslash) begin
            mode_next = qat_pkg::ModePlain;
            esc_next  = 1'b1;
          end else begin
            mode_next = qat_pkg::ModePlain;
            res[k] = qat_pkg::mk_res(qat_pkg::KindByte, in_byte, 4'(cnt),
                                     qat_pkg::StOk, 4'd0);
            k = k + 2'd1;
          end
        end
      end else if (esc) begin
        esc_next = 1'b0;
        res[k] = qat_pkg::mk_res(qat_pkg::KindByte, in_byte, 4'(cur), qat_pkg::StOk, 4'd0);
        k = k + 2'd1;
      end else if (mode == qat_pkg::ModeQuoted) begin
        if (in_byte == (dquote ? qat_pkg::ChDquote : qat_pkg::ChSquote)) begin
          res[k] = qat_pkg::mk_res(qat_pkg::KindEnd, 8'h00, 4'(cur), qat_pkg::StOk, 4'd0);
          k = k + 2'd1;
          mode_next   = qat_pkg::ModeBetween;
          dquote_next = 1'b0;
        end else if (in_byte == qat_pkg::ChBslash) begin
          esc_next = 1'b1;
        end else begin
          res[k] = qat_pkg::mk_res(qat_pkg::KindByte, in_byte, 4'(cur),
                                   qat_pkg::StOk, 4'd0);
          k = k + 2'd1;
        end
      end else begin
        if (sep) begin
          res[k] = qat_pkg::mk_res(qat_pkg::KindEnd, 8'h00, 4'(cur), qat_pkg::StOk, 4'd0);
          k = k + 2'd1;
          mode_next = qat_pkg::ModeBetween;
        end else if (in_byte == qat_pkg::ChBslash) begin
          esc_next = 1'b1;
        end else begin
          res[k] = qat_pkg::mk_res(qat_pkg::KindByte, in_byte, 4'(cur),
                                   qat_pkg::StOk, 4'd0);
          k = k + 2'd1;
        end
      end
    end

    for (int i = 0; i < qat_pkg::MaxRes; i++) begin
      if (k != 2'd0 && 2'(i) == k - 2'd1) begin
        res[i].last = 1'b1;
      end
    end
    res_n = k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= qat_pkg::ModeBetween;
      dquote <= 1'b0;
      esc    <= 1'b0;
      cnt    <= '0;
      ovf    <= 1'b0;
    end else if (step) begin
      mode   <= mode_next;
      dquote <= dquote_next;
      esc    <= esc_next;
      cnt    <= cnt_next;
      ovf    <= ovf_next;
    end
  end

endmodule

[hw/rtl/qat_resq.sv]
// Result queue: takes up to three words a cycle, hands out one
module qat_resq (
  input  logic                      clk,
  input  logic                      rst,
  input  qat_pkg::res_t             wr_data [qat_pkg::MaxRes],
  input  logic [1:0]                wr_n,
  input  logic                      rd,
  output qat_pkg::res_t             rd_data,
  output logic [qat_pkg::QLevW-1:0] level
);

  qat_pkg::res_t             mem [qat_pkg::QDepth];
  logic [qat_pkg::QAW-1:0]   wr_ptr;
  logic [qat_pkg::QAW-1:0]   rd_ptr;
  logic [qat_pkg::QLevW-1:0] level_next;

  assign rd_data    = mem[rd_ptr];
  assign level_next = level + qat_pkg::QLevW'(wr_n) - qat_pkg::QLevW'(rd);

  always_ff @(posedge clk) begin
    for (int i = 0; i < qat_pkg::MaxRes; i++) begin
      if (2'(i) < wr_n) begin
        mem[wr_ptr + qat_pkg::QAW'(i)] <= wr_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + qat_pkg::QAW'(wr_n);
      rd_ptr <= rd_ptr + qat_pkg::QAW'(rd);
      level  <= level_next;
    end
  end

endmodule

[hw/rtl/quoted_argument_tokenizer_top.sv]
// Path: an accepted word waits in the input register; its results are written into the
// result queue when it has room, and m_tdata shows the queue head. Throughput: one word a
// cycle while not stalled; a line end gives up to three results, drained one a cycle while
// m_tready is high from a four-word queue whose single output port sets that rate; input
// stalls while more than one result waits. Reset: synchronous rst returns the tokenizer to
// between-arguments and empties the input register and the queue.
`include "quoted_argument_tokenizer_top_macros.svh"

module quoted_argument_tokenizer_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] in_byte
  input  logic                       s_tlast,   // line_end
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [qat_pkg::TdataW-1:0] m_tdata,   // out_byte, token_index, status, arg_count
  output logic [1:0]                 m_tuser,   // kind
  output logic                       m_tlast    // last
);

  logic                      in_valid;
  logic [7:0]                in_byte_q;
  logic                      in_end_q;
  logic                      room;
  logic                      step;
  logic                      pop;
  qat_pkg::res_t             res [qat_pkg::MaxRes];
  logic [1:0]                res_n;
  qat_pkg::res_t             head;
  logic [qat_pkg::QLevW-1:0] level;

  // room for a full line-end burst without looking at m_tready
  assign room     = level <= qat_pkg::QLevW'(qat_pkg::QDepth - qat_pkg::MaxRes);
  assign step     = in_valid && room;
  assign s_tready = !in_valid || room;
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte_q <= s_tdata;
      in_end_q  <= s_tlast;
    end
  end

  qat_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .in_byte  (in_byte_q),
    .line_end (in_end_q),
    .res      (res),
    .res_n    (res_n)
  );

  qat_resq u_resq (
    .clk     (clk),
    .rst     (rst),
    .wr_data (res),
    .wr_n    (step ? res_n : 2'd0),
    .rd      (pop),
    .rd_data (head),
    .level   (level)
  );

  assign m_tvalid = level != '0;
  assign m_tdata  = {6'd0, head.arg_count, head.status, head.token_index, head.out_byte};
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;

  `QAT_ASSERT_ALWAYS(a_level_bound, level <= qat_pkg::QLevW'(qat_pkg::QDepth), "result queue overrun")
  `QAT_ASSERT_IMPL(a_line_is_last, m_tvalid && m_tuser == qat_pkg::KindLine, m_tlast, "line result not last")
  `QAT_ASSERT_NEXT(a_step_fills, step && in_end_q && !pop, level != '0, "line end gave no result")

endmodule

[test/tb_quoted_argument_tokenizer_top.sv]
// Testbench for the quoted argument tokenizer: directed table, random command lines, predicted words
`timescale 1ns / 100ps

module tb_quoted_argument_tokenizer_top;

  typedef struct packed {
    logic [7:0]    in_byte;
    logic          line_end;
    logic          typed;     // want holds the single result, written out by hand
    qat_pkg::res_t want;
  } cmd_word_t;

  localparam qat_pkg::res_t NoRes = '0;

  localparam cmd_word_t DirTable [25] = '{
    '{8'h00, 1'b1, 1'b1,
      '{qat_pkg::KindLine, 8'h00, 4'd0, qat_pkg::StOk, 4'd0, 1'b1}},        // empty line
    '{8'h61, 1'b0, 1'b1,
      '{qat_pkg::KindByte, 8'h61, 4'd0, qat_pkg::StOk, 4'd0, 1'b1}},
    '{8'h00, 1'b0, 1'b0, NoRes},                                         // zero byte is ordinary
    '{8'hFF, 1'b0, 1'b0, NoRes},
    '{qat_pkg::ChTab, 1'b0, 1'b0, NoRes},
    '{qat_pkg::ChSpace, 1'b0, 1'b0, NoRes},
    '{qat_pkg::ChDquote, 1'b0, 1'b0, NoRes},
    '{qat_pkg::ChSpace, 1'b0, 1'b0, NoRes},
    '{qat_pkg::ChSquote, 1'b0, 1'b0, NoRes},
    '{qat_pkg::ChBslash, 1'b0, 1'b0, NoRes},
    '{qat_pkg::ChDquote, 1'b0, 1'b0, NoRes},                             // escaped quote
    '{qat_pkg::ChDquote, 1'b0, 1'b0, NoRes},                             // closing quote
    '{8'h78, 1'b0, 1'b0, NoRes},                                         // no separator needed
    '{qat_pkg::ChBslash, 1'b0, 1'b0, NoRes},
    '{8'h00, 1'b1, 1'b0, NoRes},                                         // trailing backslash
    '{qat_pkg::ChSquote, 1'b0, 1'b0, NoRes},
    '{qat_pkg::ChDquote, 1'b0, 1'b0, NoRes},
    '{8'hA5, 1'b1, 1'b1,
      '{qat_pkg::KindLine, 8'h00, 4'd0, qat_pkg::StUnmatched, 4'd1, 1'b1}},
    '{qat_pkg::ChBslash, 1'b0, 1'b0, NoRes},
    '{qat_pkg::ChSpace, 1'b0, 1'b0, NoRes},
    '{qat_pkg::ChSquote, 1'b0, 1'b0, NoRes},                             // quote inside a token
    '{8'hFF, 1'b1, 1'b0, NoRes},
    '{qat_pkg::ChDquote, 1'b0, 1'b0, NoRes},
    '{qat_pkg::ChBslash, 1'b0, 1'b0, NoRes},
    '{8'h5A, 1'b1, 1'b0, NoRes}                                          // escape left in quotes
  };

  localparam int RandWords = 480;

  logic                       clk;
  logic                       rst      = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [7:0]                 s_tdata  = 8'h00;
  logic                       s_tlast  = 1'b0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [qat_pkg::TdataW-1:0] m_tdata;
  logic [1:0]                 m_tuser;
  logic                       m_tlast;

  quoted_argument_tokenizer_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  cmd_word_t       cmd_words [$];
  qat_pkg::res_t   expected_words [$];
  int              accept_idx = 0;
  int              rand_count = 0;
  int              fail_count = 0;
  logic            in_fire    = 1'b0;

  // tokenizer state as predicted
  qat_pkg::mode_t  scan_st = qat_pkg::ModeBetween;
  logic            dq_quote = 1'b0;
  logic            esc_pend = 1'b0;
  logic [3:0]      arg_total = 4'd0;
  logic            too_many = 1'b0;
  qat_pkg::res_t   step_res [3];
  int              step_n;

  function automatic logic is_sep(input logic [7:0] b);
    return b == qat_pkg::ChSpace || b == qat_pkg::ChTab;
  endfunction

  function automatic void emit(input qat_pkg::kind_t k, input logic [7:0] b,
                               input logic [3:0] idx, input qat_pkg::status_t st,
                               input logic [3:0] cnt);
    step_res[step_n] = '{k, b, idx, st, cnt, 1'b0};
    step_n++;
  endfunction

  function automatic void tokenize(input logic [7:0] b, input logic e);
    logic [3:0]       cur;
    qat_pkg::status_t st;
    cur    = (arg_total != 4'd0) ? arg_total - 4'd1 : 4'd0;
    st     = qat_pkg::StOk;
    step_n = 0;
    if (e) begin
      if (too_many) begin
        st = qat_pkg::StOverflow;
      end else if (scan_st != qat_pkg::ModeBetween) begin
        if (esc_pend) emit(qat_pkg::KindByte, qat_pkg::ChBslash, cur, qat_pkg::StOk, 4'd0);
        if (scan_st == qat_pkg::ModePlain) emit(qat_pkg::KindEnd, 8'h00, cur, qat_pkg::StOk, 4'd0);
        else st = qat_pkg::StUnmatched;
      end
      emit(qat_pkg::KindLine, 8'h00, 4'd0, st, arg_total);
      scan_st   = qat_pkg::ModeBetween;
      dq_quote  = 1'b0;
      esc_pend  = 1'b0;
      arg_total = 4'd0;
      too_many  = 1'b0;
    end else if (!too_many) begin
      if (scan_st == qat_pkg::ModeBetween) begin
        if (!is_sep(b)) begin
          if (arg_total >= qat_pkg::MaxArgs) begin
            too_many = 1'b1;   // rest of the line is dropped
          end else begin
            cur       = arg_total;
            arg_total = arg_total + 4'd1;
            esc_pend  = 1'b0;
            if (b == qat_pkg::ChSquote || b == qat_pkg::ChDquote) begin
              scan_st  = qat_pkg::ModeQuoted;
              dq_quote = (b == qat_pkg::ChDquote);
            end else if (b == qat_pkg::ChBslash) begin
              scan_st  = qat_pkg::ModePlain;
              esc_pend = 1'b1;
            end else begin
              scan_st = qat_pkg::ModePlain;
              emit(qat_pkg::KindByte, b, cur, qat_pkg::StOk, 4'd0);
            end
          end
        end
      end else if (esc_pend) begin
        esc_pend = 1'b0;
        emit(qat_pkg::KindByte, b, cur, qat_pkg::StOk, 4'd0);
      end else if (scan_st == qat_pkg::ModeQuoted) begin
        if (b == (dq_quote ? qat_pkg::ChDquote : qat_pkg::ChSquote)) begin
          emit(qat_pkg::KindEnd, 8'h00, cur, qat_pkg::StOk, 4'd0);
          scan_st  = qat_pkg::ModeBetween;
          dq_quote = 1'b0;
        end else if (b == qat_pkg::ChBslash) begin
          esc_pend = 1'b1;
        end else begin
          emit(qat_pkg::KindByte, b, cur, qat_pkg::StOk, 4'd0);
        end
      end else begin
        if (is_sep(b)) begin
          emit(qat_pkg::KindEnd, 8'h00, cur, qat_pkg::StOk, 4'd0);
          scan_st = qat_pkg::ModeBetween;
        end else if (b == qat_pkg::ChBslash) begin
          esc_pend = 1'b1;
        end else begin
          emit(qat_pkg::KindByte, b, cur, qat_pkg::StOk, 4'd0);
        end
      end
    end
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
  endfunction

  // stimulus generation

  function automatic void add_word(input logic [7:0] b, input logic e, input logic counted);
    cmd_words.push_back('{b, e, 1'b0, NoRes});
    if (counted) rand_count++;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom);
    while (is_sep(b) || b == qat_pkg::ChBslash || b == qat_pkg::ChDquote ||
           b == qat_pkg::ChSquote) b = 8'($urandom);
    return b;
  endfunction

  function automatic void add_sep();
    repeat ($urandom_range(1, 2))
      add_word(($urandom_range(0, 1) != 0) ? qat_pkg::ChSpace : qat_pkg::ChTab, 1'b0, 1'b1);
  endfunction

  function automatic void add_content(input logic quoted, input logic [7:0] q, input int len);
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        add_word(qat_pkg::ChBslash, 1'b0, 1'b1);
        add_word(8'($urandom), 1'b0, 1'b1);
      end else if (r == 1 && quoted) begin
        // separators and the other quote are plain text inside quotes
        case ($urandom_range(0, 2))
          0:       add_word(qat_pkg::ChSpace, 1'b0, 1'b1);
          1:       add_word(qat_pkg::ChTab, 1'b0, 1'b1);
          default: add_word((q == qat_pkg::ChDquote) ? qat_pkg::ChSquote : qat_pkg::ChDquote,
                            1'b0, 1'b1);
        endcase
      end else begin
        add_word(plain_byte(), 1'b0, 1'b1);
      end
    end
  endfunction

  function automatic void build_random();
    int         style;
    int         nargs;
    logic       counted;
    logic       joined;
    logic [7:0] q;
    while (rand_count < RandWords) begin
      style = $urandom_range(0, 9);
      if (style == 0) begin
        // noise: anything at all
        repeat ($urandom_range(0, 12)) add_word(8'($urandom), 1'b0, 1'b1);
      end else begin
        if (style == 1) nargs = $urandom_range(13, 15);
        else if (style == 2) nargs = $urandom_range(10, 12);
        else nargs = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) add_sep();
        for (int a = 0; a < nargs; a++) begin
          counted = (a < qat_pkg::MaxArgs);
          joined  = 1'b0;
          if (style == 1) begin
            add_word(plain_byte(), 1'b0, counted);
          end else if ($urandom_range(0, 2) == 0) begin
            q = ($urandom_range(0, 1) != 0) ? qat_pkg::ChDquote : qat_pkg::ChSquote;
            add_word(q, 1'b0, 1'b1);
            add_content(1'b1, q, $urandom_range(0, 4));
            if ($urandom_range(0, 9) != 0) begin
              add_word(q, 1'b0, 1'b1);
              joined = ($urandom_range(0, 2) == 0);
            end
          end else begin
            add_content(1'b0, 8'h00, $urandom_range(1, 4));
          end
          if (a < nargs - 1 && !joined) begin
            if (style == 1) add_word(qat_pkg::ChSpace, 1'b0, counted);
            else add_sep();
          end
        end
        if ($urandom_range(0, 9) == 0) add_word(qat_pkg::ChBslash, 1'b0, 1'b1);
        else if ($urandom_range(0, 5) == 0) add_sep();
      end
      add_word(8'($urandom), 1'b1, 1'b1);
    end
  endfunction

  // receiver: ready pattern cycles through four moods
  logic [9:0] ready_cyc = 10'd0;

  always @(posedge clk) begin
    ready_cyc <= ready_cyc + 10'd1;
    case (ready_cyc[9:8])
      2'd0:    m_tready <= 1'b1;
      2'd1:    m_tready <= ($urandom_range(0, 1) != 0);
      2'd2:    m_tready <= (ready_cyc[2:0] != 3'd0) && (ready_cyc[4:3] != 2'd2);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // sample between edges: nothing driven changes until the next rising edge
  always @(negedge clk) begin
    in_fire = !rst && s_tvalid && s_tready;
    if (in_fire) begin
      tokenize(s_tdata, s_tlast);
      if (cmd_words[accept_idx].typed) begin
        expected_words.push_back(cmd_words[accept_idx].want);
      end else begin
        for (int k = 0; k < step_n; k++) expected_words.push_back(step_res[k]);
      end
      accept_idx++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: kind %0d tdata %h", m_tuser, m_tdata);
        fail_count++;
      end else begin
        if (m_tuser != expected_words[0].kind) begin
          $error("kind: expected %0d, got %0d", expected_words[0].kind, m_tuser);
          fail_count++;
        end
        if (m_tdata[7:0] != expected_words[0].out_byte) begin
          $error("out_byte: expected %h, got %h", expected_words[0].out_byte, m_tdata[7:0]);
          fail_count++;
        end
        if (m_tdata[11:8] != expected_words[0].token_index) begin
          $error("token_index: expected %0d, got %0d", expected_words[0].token_index,
                 m_tdata[11:8]);
          fail_count++;
        end
        if (m_tdata[13:12] != expected_words[0].status) begin
          $error("status: expected %0d, got %0d", expected_words[0].status, m_tdata[13:12]);
          fail_count++;
        end
        if (m_tdata[17:14] != expected_words[0].arg_count) begin
          $error("arg_count: expected %0d, got %0d", expected_words[0].arg_count,
                 m_tdata[17:14]);
          fail_count++;
        end
        if (m_tlast != expected_words[0].last) begin
          $error("last: expected %0d, got %0d", expected_words[0].last, m_tlast);
          fail_count++;
        end
        void'(expected_words.pop_front());
      end
    end
  end

  initial begin
    int burst;
    int gap;
    int pause_at;
    for (int i = 0; i < $size(DirTable); i++) cmd_words.push_back(DirTable[i]);
    build_random();
    pause_at = cmd_words.size() / 2;
    burst    = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < cmd_words.size(); i++) begin
      if (i == pause_at) begin
        // hold off until the result queue has drained completely
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
      end else if (burst <= 0) begin
        if ($urandom_range(0, 4) == 0) begin
          burst = 60;
          gap   = 0;
        end else begin
          burst = $urandom_range(1, 20);
          gap   = $urandom_range(1, 6);
        end
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst--;
      s_tvalid <= 1'b1;
      s_tdata  <= cmd_words[i].in_byte;
      s_tlast  <= cmd_words[i].line_end;
      @(posedge clk);
      while (!in_fire) @(posedge clk);
    end
    s_tvalid <= 1'b0;
    while (accept_idx < cmd_words.size() || expected_words.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
